### sv/mdtg_pkg.sv
// ----------------------------------------------------------------------------
// mdtg_pkg
// Shared types, constants and helpers of the MD tag string generator.
// ----------------------------------------------------------------------------
package mdtg_pkg;

  // merged match run width and its saturation point (printable in five digits)
  localparam int unsigned RunBits     = 16;
  localparam longint unsigned RunLimitL =
    (RunBits < 17) ? ((64'd1 << RunBits) - 64'd1) : 64'd99999;
  localparam logic [RunBits-1:0] RunLimit = RunBits'(RunLimitL);

  // decimal conversion datapath
  localparam int unsigned DivW       = 17;
  localparam int unsigned RecipW     = 20;
  localparam logic [RecipW-1:0] Recip = 20'd838861;  // ceil(2^23 / 10)
  localparam int unsigned RecipShift = 23;
  localparam int unsigned DigitW     = 4;
  localparam int unsigned NumDigits  = 5;
  localparam int unsigned DigCntW    = 3;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CharW   = 7;
  localparam int unsigned CountW  = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned PhaseW  = 3;

  localparam logic [CharW-1:0] CharCaret = 7'h5E;
  localparam logic [CharW-1:0] CharZero  = 7'h30;
  localparam logic [CharW-1:0] CharNone  = 7'h00;

  // token parser phases
  localparam logic [PhaseW-1:0] PH_OPCODE  = 3'd0;
  localparam logic [PhaseW-1:0] PH_LENGTH  = 3'd1;
  localparam logic [PhaseW-1:0] PH_MISBASE = 3'd2;
  localparam logic [PhaseW-1:0] PH_INSSKIP = 3'd3;
  localparam logic [PhaseW-1:0] PH_DELBASE = 3'd4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MATCH,
    CFG_MISMATCH,
    CFG_INSERT,
    CFG_DELETE
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_MATCH,
    OP_MISMATCH,
    OP_INSERT,
    OP_DELETE
  } op_e;

  typedef struct packed {
    logic [ByteW-1:0] match_code;
    logic [ByteW-1:0] mismatch_code;
    logic [ByteW-1:0] insertion_code;
    logic [ByteW-1:0] deletion_code;
  } codes_t;

  typedef struct packed {
    logic              has_char;
    logic [CharW-1:0]  md_char;
    logic              record_end;
    logic [CountW-1:0] mismatches;
    logic [CountW-1:0] gap_opens;
    logic [CountW-1:0] gap_extends;
  } md_res_t;

  function automatic logic [CharW-1:0] base_char(input logic [ByteW-1:0] b);
    logic [CharW-1:0] c;
    case (b)
      8'd0:    c = 7'h41;  // A
      8'd1:    c = 7'h43;  // C
      8'd2:    c = 7'h47;  // G
      8'd3:    c = 7'h54;  // T
      default: c = 7'h4E;  // N
    endcase
    return c;
  endfunction

  function automatic logic [CountW-1:0] sat_add8(input logic [CountW-1:0] a,
                                                 input logic [CountW-1:0] b);
    logic [CountW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CountW] ? {CountW{1'b1}} : s[CountW-1:0];
  endfunction

endpackage

### sv/mdtg_intf.sv
// ----------------------------------------------------------------------------
// mdtg channel interfaces
// Token input, MD character output and configuration write channels.
// ----------------------------------------------------------------------------
interface mdtg_tok_if;
  logic                      valid;
  logic                      ready;
  logic [mdtg_pkg::ByteW-1:0] token_byte;
  logic                      record_last;

  modport source (output valid, output token_byte, output record_last, input ready);
  modport sink   (input valid, input token_byte, input record_last, output ready);
endinterface

interface mdtg_md_if;
  logic                        valid;
  logic                        ready;
  logic                        has_char;
  logic [mdtg_pkg::CharW-1:0]  md_char;
  logic                        record_end;
  logic [mdtg_pkg::CountW-1:0] mismatches;
  logic [mdtg_pkg::CountW-1:0] gap_opens;
  logic [mdtg_pkg::CountW-1:0] gap_extends;

  modport source (output valid, output has_char, output md_char, output record_end,
                  output mismatches, output gap_opens, output gap_extends, input ready);
  modport sink   (input valid, input has_char, input md_char, input record_end,
                  input mismatches, input gap_opens, input gap_extends, output ready);
endinterface

interface mdtg_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [mdtg_pkg::CfgIdxW-1:0] index;
  logic [mdtg_pkg::ByteW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/md_tag_string_generator.sv
// ----------------------------------------------------------------------------
// md_tag_string_generator
// Turns a mismatch-string token stream into MD tag text, one char per transfer.
// ----------------------------------------------------------------------------
// Channels: tok_i takes one token byte per transfer, record_last marks the
// final byte of an alignment. md_o gives one MD character per transfer; the
// record's last transfer has record_end set and carries the mismatch, gap
// open and gap extension counts. A record whose last byte prints and flushes
// nothing closes with a blank transfer (has_char low). cfg_i writes the four
// opcode registers (match, mismatch, insertion, deletion); it is always ready.
// The user must write it only while the block is idle; it is not enforced.
// Timing: a byte is taken while tok_i.ready is high, i.e. while idle. A
// byte that prints nothing, flushes no match run and ends no record leaves
// the input free in the next cycle; else the input is held until its
// characters are sent, and a flushed match run first goes through a single
// divide-by-ten unit one digit per cycle (up to five) and is sent as well.
// The last character sits in the output register, so the next byte may be
// taken while it waits. A stalled receiver holds md_o and, in turn, the
// sequencer. Reset clears the parser, counts, and restores default opcodes.
// ----------------------------------------------------------------------------
module md_tag_string_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  mdtg_cfg_if.sink    cfg_i,
  mdtg_tok_if.sink    tok_i,
  mdtg_md_if.source   md_o
);

  mdtg_pkg::codes_t codes_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q.match_code     <= 8'd0;
      codes_q.mismatch_code  <= 8'd1;
      codes_q.insertion_code <= 8'd2;
      codes_q.deletion_code  <= 8'd3;
    end else if (cfg_i.valid) begin
      unique case (mdtg_pkg::cfg_idx_e'(cfg_i.index))
        mdtg_pkg::CFG_MATCH:    codes_q.match_code     <= cfg_i.data;
        mdtg_pkg::CFG_MISMATCH: codes_q.mismatch_code  <= cfg_i.data;
        mdtg_pkg::CFG_INSERT:   codes_q.insertion_code <= cfg_i.data;
        mdtg_pkg::CFG_DELETE:   codes_q.deletion_code  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  mdtg_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .codes_i (codes_q),
    .tok     (tok_i),
    .md      (md_o)
  );

endmodule

### sv/mdtg_div10.sv
// ----------------------------------------------------------------------------
// mdtg_div10
// Shared divide-by-ten step: quotient by reciprocal multiply, plus remainder.
// ----------------------------------------------------------------------------
module mdtg_div10 (
  input  logic [mdtg_pkg::DivW-1:0]   value_i,
  output logic [mdtg_pkg::DivW-1:0]   quot_o,
  output logic [mdtg_pkg::DigitW-1:0] digit_o
);

  logic [mdtg_pkg::DivW+mdtg_pkg::RecipW-1:0] prod;
  logic [mdtg_pkg::DivW-1:0]                  rem;

  // exact for every value below 2^22
  assign prod   = (mdtg_pkg::DivW+mdtg_pkg::RecipW)'(value_i) *
                  (mdtg_pkg::DivW+mdtg_pkg::RecipW)'(mdtg_pkg::Recip);
  assign quot_o = mdtg_pkg::DivW'(prod >> mdtg_pkg::RecipShift);
  assign rem    = value_i - (quot_o << 3) - (quot_o << 1);
  assign digit_o = rem[mdtg_pkg::DigitW-1:0];

endmodule

### sv/mdtg_seq.sv
// ----------------------------------------------------------------------------
// mdtg_seq
// Token parser, digit conversion sequencer and output register.
// ----------------------------------------------------------------------------
module mdtg_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mdtg_pkg::codes_t codes_i,
  mdtg_tok_if.sink         tok,
  mdtg_md_if.source        md
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state_q, state_d;

  // parser state
  logic [mdtg_pkg::PhaseW-1:0]  phase_q, phase_d;
  mdtg_pkg::op_e                op_q, op_d;
  logic [mdtg_pkg::ByteW-1:0]   left_q, left_d;
  logic [mdtg_pkg::RunBits-1:0] run_q, run_d;
  logic                         pend_q, pend_d;
  logic [mdtg_pkg::CountW-1:0]  mm_q, mm_d, go_q, go_d, ge_q, ge_d;

  // per-item work registers
  logic [mdtg_pkg::CharW-1:0]   ch0_q, ch0_d, ch1_q, ch1_d;
  logic [1:0]                   main_q, main_d;
  logic                         last_q, last_d;
  logic [mdtg_pkg::CountW-1:0]  fmm_q, fmm_d, fgo_q, fgo_d, fge_q, fge_d;
  logic [mdtg_pkg::DivW-1:0]    val_q, val_d;
  logic [mdtg_pkg::DigitW-1:0]  dig_q [mdtg_pkg::NumDigits];
  logic [mdtg_pkg::DigCntW-1:0] dcnt_q, dcnt_d;

  logic             out_valid_q, out_valid_d;
  mdtg_pkg::md_res_t out_q, out_d;

  // parse results of the offered token
  logic [mdtg_pkg::PhaseW-1:0]  p_phase;
  mdtg_pkg::op_e                p_op;
  logic [mdtg_pkg::ByteW-1:0]   p_left;
  logic [mdtg_pkg::RunBits-1:0] p_run;
  logic                         p_pend;
  logic [mdtg_pkg::CountW-1:0]  p_mm, p_go, p_ge;
  logic [1:0]                   p_n;
  logic [mdtg_pkg::CharW-1:0]   p_c0, p_c1;
  logic                         p_flush_op;
  logic [mdtg_pkg::RunBits:0]   run_sum;
  logic [mdtg_pkg::ByteW-1:0]   b;
  logic [mdtg_pkg::ByteW-1:0]   left_dec;

  logic                         accept;
  logic                         slot_free;
  logic [mdtg_pkg::DivW-1:0]    quot;
  logic [mdtg_pkg::DigitW-1:0]  digit;
  logic [mdtg_pkg::DigCntW-1:0] dcnt_m1;
  logic                         more;

  assign b         = tok.token_byte;
  assign tok.ready = (state_q == S_IDLE);
  assign accept    = tok.valid && tok.ready;
  assign slot_free = !out_valid_q || md.ready;
  assign run_sum   = {1'b0, run_q} + (mdtg_pkg::RunBits+1)'(b);
  assign left_dec  = (left_q != '0) ? left_q - 8'd1 : left_q;
  assign dcnt_m1   = dcnt_q - 3'd1;

  mdtg_div10 u_div10 (
    .value_i (val_q),
    .quot_o  (quot),
    .digit_o (digit)
  );

  always_comb begin
    p_phase    = phase_q;
    p_op       = op_q;
    p_left     = left_q;
    p_run      = run_q;
    p_pend     = pend_q;
    p_mm       = mm_q;
    p_go       = go_q;
    p_ge       = ge_q;
    p_n        = 2'd0;
    p_c0       = mdtg_pkg::CharNone;
    p_c1       = mdtg_pkg::CharNone;
    p_flush_op = 1'b0;
    unique case (phase_q)
      mdtg_pkg::PH_OPCODE: begin
        // match wins over the others when codes collide
        if (b == codes_i.match_code) begin
          p_op    = mdtg_pkg::OP_MATCH;
          p_phase = mdtg_pkg::PH_LENGTH;
        end else if (b == codes_i.mismatch_code) begin
          p_flush_op = 1'b1;
          p_op       = mdtg_pkg::OP_MISMATCH;
          p_phase    = mdtg_pkg::PH_MISBASE;
        end else if (b == codes_i.insertion_code) begin
          p_flush_op = 1'b1;
          p_op       = mdtg_pkg::OP_INSERT;
          p_phase    = mdtg_pkg::PH_LENGTH;
        end else if (b == codes_i.deletion_code) begin
          p_flush_op = 1'b1;
          p_op       = mdtg_pkg::OP_DELETE;
          p_phase    = mdtg_pkg::PH_LENGTH;
        end
      end
      mdtg_pkg::PH_LENGTH: begin
        if (op_q == mdtg_pkg::OP_MATCH) begin
          p_run   = (run_sum > {1'b0, mdtg_pkg::RunLimit}) ? mdtg_pkg::RunLimit
                                                          : run_sum[mdtg_pkg::RunBits-1:0];
          p_pend  = 1'b1;
          p_phase = mdtg_pkg::PH_OPCODE;
        end else begin
          p_go   = mdtg_pkg::sat_add8(go_q, 8'd1);
          if (b != '0) p_ge = mdtg_pkg::sat_add8(ge_q, b - 8'd1);
          p_left = b;
          if (op_q == mdtg_pkg::OP_INSERT) begin
            p_phase = (b != '0) ? mdtg_pkg::PH_INSSKIP : mdtg_pkg::PH_OPCODE;
          end else begin
            p_c0 = mdtg_pkg::CharCaret;
            p_n  = 2'd1;
            if (b == '0) begin
              p_c1    = mdtg_pkg::CharZero;
              p_n     = 2'd2;
              p_phase = mdtg_pkg::PH_OPCODE;
            end else begin
              p_phase = mdtg_pkg::PH_DELBASE;
            end
          end
        end
      end
      mdtg_pkg::PH_MISBASE: begin
        p_c0    = mdtg_pkg::base_char(b);
        p_n     = 2'd1;
        p_mm    = mdtg_pkg::sat_add8(mm_q, 8'd1);
        p_phase = mdtg_pkg::PH_OPCODE;
      end
      mdtg_pkg::PH_INSSKIP: begin
        p_left = left_dec;
        if (left_dec == '0) p_phase = mdtg_pkg::PH_OPCODE;
      end
      mdtg_pkg::PH_DELBASE: begin
        p_c0   = mdtg_pkg::base_char(b);
        p_n    = 2'd1;
        p_left = left_dec;
        if (left_dec == '0) begin
          p_c1    = mdtg_pkg::CharZero;
          p_n     = 2'd2;
          p_phase = mdtg_pkg::PH_OPCODE;
        end
      end
      default: p_phase = mdtg_pkg::PH_OPCODE;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    op_d        = op_q;
    left_d      = left_q;
    run_d       = run_q;
    pend_d      = pend_q;
    mm_d        = mm_q;
    go_d        = go_q;
    ge_d        = ge_q;
    ch0_d       = ch0_q;
    ch1_d       = ch1_q;
    main_d      = main_q;
    last_d      = last_q;
    fmm_d       = fmm_q;
    fgo_d       = fgo_q;
    fge_d       = fge_q;
    val_d       = val_q;
    dcnt_d      = dcnt_q;
    more        = 1'b0;
    out_d       = out_q;
    out_valid_d = out_valid_q && !md.ready;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          phase_d = p_phase;
          op_d    = p_op;
          left_d  = p_left;
          run_d   = p_run;
          pend_d  = p_pend;
          mm_d    = p_mm;
          go_d    = p_go;
          ge_d    = p_ge;
          ch0_d   = p_c0;
          ch1_d   = p_c1;
          main_d  = p_n;
          last_d  = tok.record_last;
          fmm_d   = p_mm;
          fgo_d   = p_go;
          fge_d   = p_ge;
          dcnt_d  = '0;
          if (p_pend && (p_flush_op || tok.record_last)) begin
            val_d   = mdtg_pkg::DivW'(p_run);
            run_d   = '0;
            pend_d  = 1'b0;
            state_d = S_DIV;
          end else if ((p_n != 2'd0) || tok.record_last) begin
            state_d = S_EMIT;
          end
          if (tok.record_last) begin
            phase_d = mdtg_pkg::PH_OPCODE;
            op_d    = mdtg_pkg::OP_MATCH;
            left_d  = '0;
            run_d   = '0;
            pend_d  = 1'b0;
            mm_d    = '0;
            go_d    = '0;
            ge_d    = '0;
          end
        end
      end
      S_DIV: begin
        // one decimal digit per cycle, least significant first
        val_d  = quot;
        dcnt_d = dcnt_q + 3'd1;
        if ((quot == '0) || (dcnt_q == mdtg_pkg::DigCntW'(mdtg_pkg::NumDigits - 1))) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_d = '0;
          if (main_q != 2'd0) begin
            out_d.has_char = 1'b1;
            out_d.md_char  = ch0_q;
            ch0_d          = ch1_q;
            main_d         = main_q - 2'd1;
            more           = (main_q != 2'd1) || (dcnt_q != '0);
          end else if (dcnt_q != '0) begin
            out_d.has_char = 1'b1;
            out_d.md_char  = mdtg_pkg::CharZero + mdtg_pkg::CharW'(dig_q[dcnt_m1]);
            dcnt_d         = dcnt_m1;
            more           = (dcnt_m1 != '0);
          end
          // otherwise a silent record end: blank result with the counts
          if (!more) begin
            state_d = S_IDLE;
            if (last_q) begin
              out_d.record_end  = 1'b1;
              out_d.mismatches  = fmm_q;
              out_d.gap_opens   = fgo_q;
              out_d.gap_extends = fge_q;
            end
          end
          out_valid_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= mdtg_pkg::PH_OPCODE;
      op_q        <= mdtg_pkg::OP_MATCH;
      left_q      <= '0;
      run_q       <= '0;
      pend_q      <= 1'b0;
      mm_q        <= '0;
      go_q        <= '0;
      ge_q        <= '0;
      main_q      <= '0;
      last_q      <= 1'b0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      op_q        <= op_d;
      left_q      <= left_d;
      run_q       <= run_d;
      pend_q      <= pend_d;
      mm_q        <= mm_d;
      go_q        <= go_d;
      ge_q        <= ge_d;
      main_q      <= main_d;
      last_q      <= last_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch0_q <= ch0_d;
    ch1_q <= ch1_d;
    fmm_q <= fmm_d;
    fgo_q <= fgo_d;
    fge_q <= fge_d;
    val_q <= val_d;
    out_q <= out_d;
    if (state_q == S_DIV) begin
      dig_q[dcnt_q] <= digit;
    end
  end

  assign md.valid       = out_valid_q;
  assign md.has_char    = out_q.has_char;
  assign md.md_char     = out_q.md_char;
  assign md.record_end  = out_q.record_end;
  assign md.mismatches  = out_q.mismatches;
  assign md.gap_opens   = out_q.gap_opens;
  assign md.gap_extends = out_q.gap_extends;

endmodule

### sv/mdtg_checker.sv
// ----------------------------------------------------------------------------
// mdtg_checker
// Port-level checks on the MD character output channel.
// ----------------------------------------------------------------------------
module mdtg_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        md_valid,
  input logic                        md_ready,
  input logic                        md_has_char,
  input logic [mdtg_pkg::CharW-1:0]  md_char,
  input logic                        md_record_end,
  input logic [mdtg_pkg::CountW-1:0] md_mismatches,
  input logic [mdtg_pkg::CountW-1:0] md_gap_opens,
  input logic [mdtg_pkg::CountW-1:0] md_gap_extends
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_valid && !md_ready |=> md_valid && $stable(md_char) && $stable(md_has_char)
                              && $stable(md_record_end))
    else $error("md output changed while stalled");

  a_blank_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_valid && !md_has_char |-> md_record_end && (md_char == '0))
    else $error("blank result not at record end");

  a_counts_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_valid && !md_record_end |->
      (md_mismatches == '0) && (md_gap_opens == '0) && (md_gap_extends == '0))
    else $error("counts shown before record end");

  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_valid && md_has_char |->
      ((md_char >= 7'h30) && (md_char <= 7'h39)) || (md_char == 7'h41) ||
      (md_char == 7'h43) || (md_char == 7'h47) || (md_char == 7'h54) ||
      (md_char == 7'h4E) || (md_char == 7'h5E))
    else $error("illegal MD character");

endmodule

bind md_tag_string_generator mdtg_checker u_mdtg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .md_valid       (md_o.valid),
  .md_ready       (md_o.ready),
  .md_has_char    (md_o.has_char),
  .md_char        (md_o.md_char),
  .md_record_end  (md_o.record_end),
  .md_mismatches  (md_o.mismatches),
  .md_gap_opens   (md_o.gap_opens),
  .md_gap_extends (md_o.gap_extends)
);
